// ===== hdl/spf_pkg.sv =====
package spf_pkg;

   // fixed field widths of the channels
   localparam int VALUE_W = 18;

   // default table limit
   localparam int MAX_VALUE_DEF = 262143;

   // sequencer states: table build, then per-value factoring
   typedef enum logic [3:0] {
      ST_FILL,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_MARK_RD,
      ST_MARK_CHK,
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_FETCH,
      ST_FINISH
   } state_type;

endpackage

// ===== hdl/smallest_prime_factor_factorizer.sv =====
// channel  dir  transfer when           ports
// req      in   req_valid & !req_stall  req_valid req_stall req_value
// rsp      out  rsp_valid & !rsp_stall  rsp_valid rsp_stall rsp_prime rsp_has_prime rsp_last
//
// after reset a clearing pass writes every table entry, then the sieve runs, each table
// read going through a read state and a check state; req_stall stays high until the table
// is complete.
// per value: an accept state, then per prime factor (with repeats) a lookup, a divider pass
// at two quotient bits per step and a fetch, the last fetch replaced by the final result state;
// a value with no prime goes straight to the final result, and rsp_stall can hold a result.
module smallest_prime_factor_factorizer
   import spf_pkg::*;
#(
   parameter int MAX_VALUE = MAX_VALUE_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VALUE_W-1:0] rsp_prime,
   output logic               rsp_has_prime,
   output logic               rsp_last
);

   localparam int AW      = $clog2(MAX_VALUE + 1);
   localparam int DEPTH   = MAX_VALUE + 1;
   localparam int DW      = AW + (AW % 2);
   localparam int DIV_CYC = DW / 2;
   localparam int CW      = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
   localparam int WIDE    = (AW > VALUE_W) ? AW : VALUE_W;

   // factor table
   logic [AW-1:0] mem [DEPTH];
   logic [AW-1:0] rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [AW-1:0] mem_wdata;
   logic [AW-1:0] mem_raddr;

   state_type state_ff, state_in;

   // sieve counters
   logic [AW-1:0] fill_ff, fill_in;
   logic [AW:0]   i_ff, i_in;
   logic [AW:0]   j_ff, j_in;

   // factoring state
   logic [AW-1:0] rem_ff, rem_in;
   logic [AW-1:0] prev_ff, prev_in;
   logic [AW-1:0] pend_ff, pend_in;
   logic          pend_valid_ff, pend_valid_in;

   // divider
   logic [DW-1:0] quo_ff, quo_in;
   logic [AW-1:0] part_ff, part_in;
   logic [AW-1:0] div_ff, div_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] quo_step;
   logic [AW-1:0] part_step;

   // result register
   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_prime_ff, rsp_prime_in;
   logic               rsp_has_prime_ff, rsp_has_prime_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               emit;
   logic               out_free;

   logic [WIDE-1:0] val_wide;
   logic [WIDE-1:0] pend_wide;
   logic            val_bad;
   logic [AW:0]     i_next;
   logic [AW:0]     j_next;
   logic            f_new;

   assign val_wide  = WIDE'(req_value);
   assign pend_wide = WIDE'(pend_ff);
   assign val_bad   = (val_wide < WIDE'(2)) || (val_wide > WIDE'(MAX_VALUE));
   assign i_next    = i_ff + (AW+1)'(2);
   assign j_next    = j_ff + i_ff;
   assign f_new     = (rdata_ff != prev_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // table memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   // two restoring division steps per cycle
   always_comb begin
      logic [AW:0] sh;
      quo_step  = quo_ff;
      part_step = part_ff;
      for (int k = 0; k < 2; k++) begin
         sh = {part_step, quo_step[DW-1]};
         if (sh >= {1'b0, div_ff}) begin
            part_step = AW'(sh - {1'b0, div_ff});
            quo_step  = {quo_step[DW-2:0], 1'b1};
         end else begin
            part_step = sh[AW-1:0];
            quo_step  = {quo_step[DW-2:0], 1'b0};
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_FILL: begin
            if (fill_ff == AW'(MAX_VALUE)) state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            if (rdata_ff == '0)                       state_in = ST_MARK_RD;
            else if (i_next > (AW+1)'(MAX_VALUE))     state_in = ST_IDLE;
            else                                      state_in = ST_SCAN_RD;
         end
         ST_MARK_RD: state_in = ST_MARK_CHK;
         ST_MARK_CHK: begin
            if (j_next <= (AW+1)'(MAX_VALUE))         state_in = ST_MARK_RD;
            else if (i_next > (AW+1)'(MAX_VALUE))     state_in = ST_IDLE;
            else                                      state_in = ST_SCAN_RD;
         end
         ST_IDLE: begin
            if (req_valid) state_in = val_bad ? ST_FINISH : ST_EVAL;
         end
         ST_EVAL: begin
            if (rdata_ff < AW'(2))                        state_in = ST_FINISH;
            else if (!(f_new && pend_valid_ff && !out_free)) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == CW'(DIV_CYC - 1)) begin
               state_in = (quo_step > DW'(1)) ? ST_FETCH : ST_FINISH;
            end
         end
         ST_FETCH: state_in = ST_EVAL;
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_FILL;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall        = 1'b1;
      mem_we           = 1'b0;
      mem_waddr        = fill_ff;
      mem_wdata        = '0;
      mem_raddr        = rem_ff;
      emit             = 1'b0;
      rsp_prime_in     = pend_wide[VALUE_W-1:0];
      rsp_has_prime_in = 1'b1;
      rsp_last_in      = 1'b0;
      fill_in          = fill_ff;
      i_in             = i_ff;
      j_in             = j_ff;
      rem_in           = rem_ff;
      prev_in          = prev_ff;
      pend_in          = pend_ff;
      pend_valid_in    = pend_valid_ff;
      quo_in           = quo_ff;
      part_in          = part_ff;
      div_in           = div_ff;
      cnt_in           = cnt_ff;
      case (state_ff)
         // clearing pass: evens get 2, the rest 0
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = fill_ff;
            if (fill_ff >= AW'(2) && !fill_ff[0]) mem_wdata = AW'(2);
            fill_in   = fill_ff + AW'(1);
            i_in      = (AW+1)'(3);
         end
         ST_SCAN_RD: begin
            mem_raddr = i_ff[AW-1:0];
         end
         // unmarked odd entry is prime: start marking at itself
         ST_SCAN_CHK: begin
            if (rdata_ff == '0) j_in = i_ff;
            else                i_in = i_next;
         end
         ST_MARK_RD: begin
            mem_raddr = j_ff[AW-1:0];
         end
         ST_MARK_CHK: begin
            if (rdata_ff == '0) begin
               mem_we    = 1'b1;
               mem_waddr = j_ff[AW-1:0];
               mem_wdata = i_ff[AW-1:0];
            end
            j_in = j_next;
            if (j_next > (AW+1)'(MAX_VALUE)) i_in = i_next;
         end
         // take a value, look up its factor
         ST_IDLE: begin
            req_stall     = 1'b0;
            mem_raddr     = val_wide[AW-1:0];
            rem_in        = val_wide[AW-1:0];
            prev_in       = AW'(1);
            pend_valid_in = 1'b0;
         end
         // new distinct prime pushes the pending one out
         ST_EVAL: begin
            if (rdata_ff >= AW'(2) && !(f_new && pend_valid_ff && !out_free)) begin
               if (f_new) begin
                  emit          = pend_valid_ff;
                  pend_in       = rdata_ff;
                  pend_valid_in = 1'b1;
                  prev_in       = rdata_ff;
               end
               quo_in  = DW'(rem_ff);
               part_in = '0;
               div_in  = rdata_ff;
               cnt_in  = '0;
            end
         end
         ST_DIV: begin
            quo_in  = quo_step;
            part_in = part_step;
            cnt_in  = cnt_ff + CW'(1);
            if (cnt_ff == CW'(DIV_CYC - 1)) rem_in = quo_step[AW-1:0];
         end
         ST_FETCH: begin
            mem_raddr = rem_ff;
         end
         // final result, or the no-prime result
         ST_FINISH: begin
            emit        = out_free;
            rsp_last_in = 1'b1;
            if (!pend_valid_ff) begin
               rsp_prime_in     = '0;
               rsp_has_prime_in = 1'b0;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FILL;
         fill_ff       <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         if (emit)           rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      prev_ff <= prev_in;
      pend_ff <= pend_in;
      quo_ff  <= quo_in;
      part_ff <= part_in;
      div_ff  <= div_in;
      if (emit) begin
         rsp_prime_ff     <= rsp_prime_in;
         rsp_has_prime_ff <= rsp_has_prime_in;
         rsp_last_ff      <= rsp_last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_prime     = rsp_prime_ff;
   assign rsp_has_prime = rsp_has_prime_ff;
   assign rsp_last      = rsp_last_ff;

   // a result is only loaded when the register can take it
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result loaded over a stalled result");

   // table is written only while it is being built
   a_write_build: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_FILL || state_ff == ST_MARK_CHK))
      else $error("table write outside the build");

   // an accepted value goes to lookup or straight to the final result
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_EVAL || state_ff == ST_FINISH))
      else $error("bad state after value transfer");

   // the divider never runs with a divisor below two
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_ff >= AW'(2)))
      else $error("divisor below two");

   // a result without a prime is always alone and zero
   a_noprime_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_prime) |-> (rsp_last && rsp_prime == '0))
      else $error("no-prime result malformed");

endmodule
